### rtl/bytecode_line_lookup_assert.svh
// ----------------------------------------------------------------------------
// Bytecode line lookup assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BYTECODE_LINE_LOOKUP_ASSERT_SVH
`define BYTECODE_LINE_LOOKUP_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define BLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define BLL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BLL_ASSERT(lbl, prop, msg)
`define BLL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/bll_pkg.sv
// ----------------------------------------------------------------------------
// Bytecode line lookup package
// Table sizing, command and result codes, and records shared by the cells.
// ----------------------------------------------------------------------------
package bll_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W       = CNT_W + 1;
  localparam int unsigned PROBE_CELLS = CNT_W - 1;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned LINE_W      = 16;
  localparam int unsigned VAL_W       = 17;
  localparam int unsigned ENTRY_W     = POS_W + LINE_W;

  localparam logic signed [VAL_W-1:0] LINE_EMPTY = -17'sd101;
  localparam logic signed [VAL_W-1:0] LINE_NONE  = -17'sd102;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } bll_cmd_e;

  typedef enum logic [2:0] {
    KIND_EXACT  = 3'd0,
    KIND_PRED   = 3'd1,
    KIND_EMPTY  = 3'd2,
    KIND_BEFORE = 3'd3,
    KIND_PASS   = 3'd4
  } bll_kind_e;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_READ,
    SCAN_EVAL,
    SCAN_DONE
  } bll_scan_e;

  // Table write broadcast to every bank.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [POS_W-1:0]  start;
    logic [LINE_W-1:0] line;
  } bll_wr_t;

  // Query state handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [POS_W-1:0]  idx;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] half;
    logic [LINE_W-1:0] line;
  } bll_probe_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] line_value;
    bll_kind_e               kind;
  } bll_res_t;

endpackage

### rtl/bll_if.sv
// ----------------------------------------------------------------------------
// Bytecode line lookup channels
// Valid/ready interfaces for the command channel and the result channel.
// ----------------------------------------------------------------------------
interface bll_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        entry_start;
  logic [15:0]        entry_line;
  logic signed [16:0] query_index;

  modport source (output valid, command, entry_start, entry_line, query_index,
                  input ready);
  modport sink (input valid, command, entry_start, entry_line, query_index,
                output ready);
endinterface

interface bll_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] line_value;
  logic [2:0]         result_kind;

  modport source (output valid, line_value, result_kind, input ready);
  modport sink (input valid, line_value, result_kind, output ready);
endinterface

### rtl/bll_probe_cell.sv
// ----------------------------------------------------------------------------
// Bytecode line lookup probe cell
// One halving step: own table bank, registered read, compare, hand on.
// ----------------------------------------------------------------------------
module bll_probe_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bll_pkg::bll_wr_t          wr_i,
  input  logic [bll_pkg::CNT_W-1:0] count_i,
  input  bll_pkg::bll_probe_t       prev_i,
  output bll_pkg::bll_probe_t       next_o
);
  import bll_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [SUM_W-1:0]   sum;
  logic [ADDR_W-1:0]  probe;
  logic [ADDR_W-1:0]  probe_q;
  bll_probe_t         s1_q;
  bll_probe_t         out_d;
  bll_probe_t         out_q;
  logic [POS_W-1:0]   rd_start;
  logic [LINE_W-1:0]  rd_line;

  // Probe position, clamped to the last entry.
  assign sum   = SUM_W'(prev_i.base) + SUM_W'(prev_i.half);
  assign probe = (sum >= SUM_W'(count_i)) ? ADDR_W'(count_i - 1'b1) : sum[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.start, wr_i.line};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[probe];
    probe_q <= probe;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      out_q <= '0;
    end else begin
      s1_q  <= prev_i;
      out_q <= out_d;
    end
  end

  assign rd_start = rdata_q[ENTRY_W-1 -: POS_W];
  assign rd_line  = rdata_q[LINE_W-1:0];

  always_comb begin
    out_d = s1_q;
    if (s1_q.valid && !s1_q.done && (s1_q.half != '0)) begin
      if (s1_q.idx > rd_start) begin
        out_d.base = probe_q;
      end else if (s1_q.idx == rd_start) begin
        out_d.done = 1'b1;
        out_d.line = rd_line;
      end
      out_d.half = s1_q.half >> 1;
    end
  end

  assign next_o = out_q;

endmodule

### rtl/bll_scan_unit.sv
// ----------------------------------------------------------------------------
// Bytecode line lookup scan unit
// Forward scan from the search base; holds the result until taken.
// ----------------------------------------------------------------------------
module bll_scan_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bll_pkg::bll_wr_t          wr_i,
  input  logic [bll_pkg::CNT_W-1:0] count_i,
  input  bll_pkg::bll_probe_t       start_i,
  output bll_pkg::bll_res_t         res_o,
  input  logic                      res_ready_i,
  output logic                      busy_o
);
  import bll_pkg::*;

  logic [ENTRY_W-1:0]      mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]      rdata_q;
  bll_scan_e               state_q, state_d;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic [POS_W-1:0]        idx_q, idx_d;
  logic signed [VAL_W-1:0] line_q, line_d;
  bll_kind_e               kind_q, kind_d;
  logic [POS_W-1:0]        rd_start;
  logic [LINE_W-1:0]       rd_line;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.start, wr_i.line};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[pos_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    line_q <= line_d;
    kind_q <= kind_d;
  end

  assign rd_start = rdata_q[ENTRY_W-1 -: POS_W];
  assign rd_line  = rdata_q[LINE_W-1:0];

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    line_d  = line_q;
    kind_d  = kind_q;
    case (state_q)
      SCAN_IDLE: begin
        if (start_i.valid) begin
          idx_d = start_i.idx;
          pos_d = CNT_W'(start_i.base);
          if (start_i.done) begin
            line_d  = $signed({1'b0, start_i.line});
            kind_d  = KIND_EXACT;
            state_d = SCAN_DONE;
          end else begin
            line_d  = LINE_NONE;
            kind_d  = KIND_BEFORE;
            state_d = SCAN_READ;
          end
        end
      end
      SCAN_READ: begin
        // Read issued at pos_q this cycle; stop at the end of the table.
        state_d = (pos_q >= count_i) ? SCAN_DONE : SCAN_EVAL;
      end
      SCAN_EVAL: begin
        if (idx_q < rd_start) begin
          state_d = SCAN_DONE;
        end else if (idx_q == rd_start) begin
          line_d  = $signed({1'b0, rd_line});
          kind_d  = KIND_EXACT;
          state_d = SCAN_DONE;
        end else begin
          line_d  = $signed({1'b0, rd_line});
          kind_d  = KIND_PRED;
          pos_d   = pos_q + 1'b1;
          state_d = SCAN_READ;
        end
      end
      SCAN_DONE: begin
        if (res_ready_i) begin
          state_d = SCAN_IDLE;
        end
      end
      default: state_d = SCAN_IDLE;
    endcase
  end

  assign res_o.valid      = (state_q == SCAN_DONE);
  assign res_o.line_value = line_q;
  assign res_o.kind       = kind_q;
  assign busy_o           = (state_q != SCAN_IDLE);

endmodule

### rtl/bytecode_line_lookup.sv
// ----------------------------------------------------------------------------
// Bytecode line lookup
// Sorted (start, line) table with predecessor search over a chain of cells.
// ----------------------------------------------------------------------------
//
//   channel  dir  modport     carries
//   in_i     in   sink        command, entry_start, entry_line, query_index
//   out_o    out  source      line_value, result_kind (one per query)
//
// A query on a non-positive index or an empty table lands in the output
// register in the cycle it is taken. Other queries walk the probe chain of
// log2(TABLE_DEPTH) cells, each a registered read and a registered compare,
// then the scan, which reads entries forward to the index or the table end.
// One query is in flight at a time; in_i.ready drops until its result moves to
// the output register. Reset empties the table; entries are not cleared.
// ----------------------------------------------------------------------------
`include "bytecode_line_lookup_assert.svh"

module bytecode_line_lookup (
  input  logic       clk_i,
  input  logic       rst_ni,
  bll_in_if.sink     in_i,
  bll_out_if.source  out_o
);
  import bll_pkg::*;

  logic                    in_acc;
  bll_cmd_e                cmd;
  logic                    idx_nonpos;
  logic                    is_query;
  logic                    direct_res;
  logic                    chain_start;
  logic [CNT_W-1:0]        count_q;
  logic                    busy_q;
  bll_wr_t                 wr;
  bll_probe_t              link [PROBE_CELLS+1];
  logic [PROBE_CELLS+1:0]  flight_vld;
  bll_res_t                scan_res;
  logic                    scan_busy;
  logic                    res_ready;
  logic                    out_free;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_line_q;
  bll_kind_e               out_kind_q;

  // Accept while no query is in flight and the output slot can take a result.
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !busy_q && out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd        = bll_cmd_e'(in_i.command);

  assign idx_nonpos  = in_i.query_index[VAL_W-1] || (in_i.query_index == '0);
  assign is_query    = in_acc && (cmd == CMD_QUERY);
  assign direct_res  = is_query && (idx_nonpos || (count_q == '0));
  assign chain_start = is_query && !direct_res;

  // Append: broadcast to every bank, drop once the table is full.
  assign wr.en    = in_acc && (cmd == CMD_APPEND) && (count_q < CNT_W'(TABLE_DEPTH));
  assign wr.addr  = count_q[ADDR_W-1:0];
  assign wr.start = in_i.entry_start;
  assign wr.line  = in_i.entry_line;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_acc) begin
      case (cmd)
        CMD_CLEAR:  count_q <= '0;
        CMD_APPEND: begin
          if (wr.en) begin
            count_q <= count_q + 1'b1;
          end
        end
        default: count_q <= count_q;
      endcase
    end
  end

  // Head of the chain: search starts at base 0 with half the entry count.
  assign link[0].valid = chain_start;
  assign link[0].done  = 1'b0;
  assign link[0].idx   = in_i.query_index[POS_W-1:0];
  assign link[0].base  = '0;
  assign link[0].half  = ADDR_W'(count_q >> 1);
  assign link[0].line  = '0;

  for (genvar c = 0; c < PROBE_CELLS; c++) begin : g_cell
    bll_probe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .count_i (count_q),
      .prev_i  (link[c]),
      .next_o  (link[c+1])
    );
  end

  bll_scan_unit u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .count_i     (count_q),
    .start_i     (link[PROBE_CELLS]),
    .res_o       (scan_res),
    .res_ready_i (res_ready),
    .busy_o      (scan_busy)
  );

  assign res_ready = out_free;

  // Hold busy from chain entry until the scan result moves out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (chain_start) begin
      busy_q <= 1'b1;
    end else if (scan_res.valid && res_ready) begin
      busy_q <= 1'b0;
    end
  end

  // Output register: load a direct result or the scan result, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (direct_res || (scan_res.valid && res_ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (direct_res) begin
      if (idx_nonpos) begin
        out_line_q <= in_i.query_index;
        out_kind_q <= KIND_PASS;
      end else begin
        out_line_q <= LINE_EMPTY;
        out_kind_q <= KIND_EMPTY;
      end
    end else if (scan_res.valid && res_ready) begin
      out_line_q <= scan_res.line_value;
      out_kind_q <= scan_res.kind;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.line_value  = out_line_q;
  assign out_o.result_kind = out_kind_q;

  for (genvar v = 0; v <= PROBE_CELLS; v++) begin : g_vld
    assign flight_vld[v] = link[v].valid;
  end
  assign flight_vld[PROBE_CELLS+1] = scan_busy;

  `BLL_ASSERT(a_one_in_flight, $onehot0(flight_vld), "more than one query in flight")
  `BLL_ASSERT(a_count_range, count_q <= CNT_W'(TABLE_DEPTH), "entry count past depth")
  `BLL_ASSERT(a_res_when_busy, scan_res.valid |-> busy_q, "scan result with no query")
  `BLL_ASSERT_NEVER(a_no_double_load, direct_res && scan_res.valid, "two results at once")

endmodule
